// ===== rtl/awu_pkg.sv =====
package awu_pkg;

  // Quiet NaN returned by every arithmetic operation that yields a NaN
  localparam logic [31:0] QNAN   = 32'h7FC0_0000;
  localparam logic [31:0] FP_ONE = 32'h3F80_0000;

  // Register defaults
  localparam logic [31:0] RST_STEP_SIZE = 32'h38D1_B717;
  localparam logic [31:0] RST_BETA_ONE  = 32'h3F66_6666;
  localparam logic [31:0] RST_BETA_TWO  = 32'h3F7F_BE77;
  localparam logic [31:0] RST_EPSILON   = 32'h322B_CC77;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ADAM_ENABLE = 3'd0,
    CFG_STEP_SIZE   = 3'd1,
    CFG_BETA_ONE    = 3'd2,
    CFG_BETA_TWO    = 3'd3,
    CFG_EPSILON     = 3'd4
  } cfg_idx_t;

  // One quotient / root bit per stage
  localparam int SQRT_STEPS = 27;
  localparam int DIV_STEPS  = 27;
  // front (4) + sqrt setup, steps, round + eps add + div setup, steps, round + final add
  localparam int LATENCY = 4 + 1 + SQRT_STEPS + 1 + 1 + 1 + DIV_STEPS + 1 + 1;

  typedef struct packed {
    logic [31:0] weight_in;
    logic [31:0] grad_accum;
    logic [31:0] moment_in;
    logic [31:0] velocity_in;
    logic [31:0] mirror_in;
    logic        last_element;
  } item_t;

  typedef struct packed {
    logic [31:0] weight_out;
    logic [31:0] moment_out;
    logic [31:0] velocity_out;
    logic        last_out;
  } result_t;

  // Front stage payloads
  typedef struct packed {
    logic [31:0] w;
    logic [31:0] g;
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] c1;
    logic [31:0] c2;
    logic        last;
  } s1_t;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] g;
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] t1;
    logic [31:0] t2;
    logic        last;
  } s2_t;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] v;
    logic [31:0] a2;
    logic [31:0] mom;
    logic [31:0] t3;
    logic        last;
  } s3_t;

  // Fields that ride along through the root and divide sections
  typedef struct packed {
    logic [31:0] w;
    logic [31:0] mom;
    logic [31:0] vel;
    logic [31:0] num;
    logic        last;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic [31:0] x;
  } root_t;

  typedef struct packed {
    logic [23:0]        mant;
    logic signed [9:0]  expo;
  } unp_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        sval;
    logic signed [9:0]  e;
    logic [53:0]        rad;
    logic [29:0]        rem;
    logic [26:0]        q;
  } sqrt_st_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        sval;
    logic               sign;
    logic signed [9:0]  e;
    logic [23:0]        dvs;
    logic [24:0]        rem;
    logic [26:0]        q;
  } div_st_t;

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // Nonzero finite operand to 1.f mantissa and unbiased exponent
  function automatic unp_t unpack_norm(logic [31:0] x);
    unp_t       u;
    logic [4:0] pos;
    logic [4:0] lz;
    pos = '0;
    if (x[30:23] != 8'd0) begin
      u.mant = {1'b1, x[22:0]};
      u.expo = $signed({2'b00, x[30:23]}) - 10'sd127;
    end else begin
      for (int i = 0; i < 23; i++) begin
        if (x[i]) pos = 5'(i);
      end
      lz = 5'd23 - pos;
      u.mant = {1'b0, x[22:0]} << lz;
      u.expo = -10'sd126 - $signed({5'b0, lz});
    end
    return u;
  endfunction

  // sig[26] is the leading bit, value = sig/2^26 * 2^(e-127); bit 0 is sticky.
  // Round to nearest even, subnormal and overflow handling.
  function automatic logic [31:0] round_pack(logic sign, logic signed [9:0] e,
                                             logic [26:0] sig);
    logic [26:0] s2;
    logic [26:0] mask;
    logic [9:0]  shamt;
    logic [9:0]  ebase;
    logic        up;
    logic [24:0] mant;
    logic [9:0]  ef;
    if (e <= 10'sd0) begin
      shamt = $unsigned(10'sd1 - e);
      if (shamt > 10'd26) begin
        s2 = {26'b0, |sig};
      end else begin
        mask = (27'd1 << shamt) - 27'd1;
        s2   = (sig >> shamt) | {26'b0, |(sig & mask)};
      end
      ebase = 10'd0;
    end else begin
      s2    = sig;
      ebase = $unsigned(e) - 10'd1;
    end
    up   = s2[2] & (s2[3] | s2[1] | s2[0]);
    mant = {1'b0, s2[26:3]} + {24'b0, up};
    ef   = ebase + {8'b0, mant[24:23]};
    if (ef >= 10'd255) return {sign, 8'hFF, 23'b0};
    return {sign, ef[7:0], mant[22:0]};
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0]       big;
    logic [31:0]       sml;
    logic [23:0]       mbig;
    logic [23:0]       msml;
    logic [7:0]        ebig;
    logic [7:0]        esml;
    logic [7:0]        d;
    logic [26:0]       b27;
    logic [26:0]       s27;
    logic [26:0]       s_sh;
    logic [26:0]       mask;
    logic [27:0]       sum;
    logic [4:0]        pos;
    logic [4:0]        lsh;
    logic [26:0]       sig;
    logic signed [9:0] e;
    pos = '0;
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mbig = {big[30:23] != 8'd0, big[22:0]};
    msml = {sml[30:23] != 8'd0, sml[22:0]};
    d    = ebig - esml;
    b27  = {mbig, 3'b000};
    s27  = {msml, 3'b000};
    // align the smaller operand, keep shifted-out bits as sticky
    if (d > 8'd26) begin
      s_sh = {26'b0, |msml};
    end else begin
      mask = (27'd1 << d) - 27'd1;
      s_sh = (s27 >> d) | {26'b0, |(s27 & mask)};
    end
    if (a[31] ^ b[31]) sum = {1'b0, b27} - {1'b0, s_sh};
    else sum = {1'b0, b27} + {1'b0, s_sh};
    if (sum == 28'd0) return {a[31] & b[31], 31'b0};
    for (int i = 0; i < 28; i++) begin
      if (sum[i]) pos = 5'(i);
    end
    if (sum[27]) begin
      sig = {sum[27:2], |sum[1:0]};
      e   = $signed({2'b00, ebig}) + 10'sd1;
    end else begin
      lsh = 5'd26 - pos;
      sig = sum[26:0] << lsh;
      e   = $signed({2'b00, ebig}) - $signed({5'b0, lsh});
    end
    return round_pack(big[31], e, sig);
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    unp_t              ua;
    unp_t              ub;
    logic [47:0]       p;
    logic [26:0]       sig;
    logic signed [9:0] e;
    logic              s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QNAN;
    if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'b0};
    if (is_zero(a) || is_zero(b)) return {s, 31'b0};
    ua = unpack_norm(a);
    ub = unpack_norm(b);
    p  = ua.mant * ub.mant;
    if (p[47]) begin
      sig = {p[47:22], |p[21:0]};
      e   = $signed(ua.expo) + $signed(ub.expo) + 10'sd128;
    end else begin
      sig = {p[46:21], |p[20:0]};
      e   = $signed(ua.expo) + $signed(ub.expo) + 10'sd127;
    end
    return round_pack(s, e, sig);
  endfunction

  // Square root: setup, one root bit per step, rounding
  function automatic sqrt_st_t sqrt_init(logic [31:0] x);
    sqrt_st_t          st;
    unp_t              u;
    logic signed [9:0] p;
    logic [24:0]       m25;
    st = '0;
    if (is_nan(x)) begin
      st.special = 1'b1;
      st.sval    = QNAN;
    end else if (is_zero(x)) begin
      st.special = 1'b1;
      st.sval    = x;
    end else if (x[31]) begin
      st.special = 1'b1;
      st.sval    = QNAN;
    end else if (is_inf(x)) begin
      st.special = 1'b1;
      st.sval    = x;
    end else begin
      u   = unpack_norm(x);
      p   = $signed(u.expo) - 10'sd23;
      m25 = {1'b0, u.mant};
      // make the exponent even
      if (p[0]) begin
        m25 = {u.mant, 1'b0};
        p   = p - 10'sd1;
      end
      st.rad = {1'b0, m25, 28'b0};
      st.e   = (p >>> 1) + 10'sd138;
    end
    return st;
  endfunction

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t    n;
    logic [29:0] rs;
    logic [29:0] tr;
    n  = s;
    rs = {s.rem[27:0], s.rad[53:52]};
    tr = {1'b0, s.q, 2'b01};
    if (rs >= tr) begin
      n.rem = rs - tr;
      n.q   = {s.q[25:0], 1'b1};
    end else begin
      n.rem = rs;
      n.q   = {s.q[25:0], 1'b0};
    end
    n.rad = {s.rad[51:0], 2'b00};
    return n;
  endfunction

  function automatic logic [31:0] sqrt_finish(sqrt_st_t s);
    logic st;
    st = (s.rem != 30'd0);
    if (s.special) return s.sval;
    if (s.q[26]) return round_pack(1'b0, s.e + 10'sd1, {s.q[26:1], s.q[0] | st});
    return round_pack(1'b0, s.e, {s.q[25:0], st});
  endfunction

  // Division: setup, one quotient bit per step, rounding
  function automatic div_st_t div_init(logic [31:0] a, logic [31:0] b);
    div_st_t d;
    unp_t    ua;
    unp_t    ub;
    d      = '0;
    d.sign = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b)) ||
        (is_inf(a) && is_inf(b))) begin
      d.special = 1'b1;
      d.sval    = QNAN;
    end else if (is_inf(a) || is_zero(b)) begin
      d.special = 1'b1;
      d.sval    = {d.sign, 8'hFF, 23'b0};
    end else if (is_zero(a) || is_inf(b)) begin
      d.special = 1'b1;
      d.sval    = {d.sign, 31'b0};
    end else begin
      ua    = unpack_norm(a);
      ub    = unpack_norm(b);
      d.dvs = ub.mant;
      d.rem = {1'b0, ua.mant};
      d.e   = $signed(ua.expo) - $signed(ub.expo) + 10'sd126;
    end
    return d;
  endfunction

  function automatic div_st_t div_step(div_st_t d);
    div_st_t     n;
    logic [24:0] r;
    logic        qb;
    n = d;
    if (d.rem >= {1'b0, d.dvs}) begin
      r  = d.rem - {1'b0, d.dvs};
      qb = 1'b1;
    end else begin
      r  = d.rem;
      qb = 1'b0;
    end
    n.q   = {d.q[25:0], qb};
    n.rem = {r[23:0], 1'b0};
    return n;
  endfunction

  function automatic logic [31:0] div_finish(div_st_t d);
    logic st;
    st = (d.rem != 25'd0);
    if (d.special) return d.sval;
    if (d.q[26]) return round_pack(d.sign, d.e + 10'sd1, {d.q[26:1], d.q[0] | st});
    return round_pack(d.sign, d.e, {d.q[25:0], st});
  endfunction

endpackage

// ===== rtl/adam_weight_update.sv =====
// Throughput: one item per cycle; the square root and the divide each resolve
// one bit per pipeline stage (27 stages apiece) and set most of the latency.
// rst (synchronous, active high) clears all stage valid bits and loads the
// default registers; busy is high only during reset. done cannot be stalled.
module adam_weight_update (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  awu_pkg::item_t    item,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [31:0]       wr_data,
  output logic              done,
  output awu_pkg::result_t  result
);
  import awu_pkg::*;

  logic        adam_enable;
  logic [31:0] step_size;
  logic [31:0] beta_one;
  logic [31:0] beta_two;
  logic [31:0] epsilon_term;

  logic        accept;

  logic        s1_v, s2_v, s3_v, s4_v;
  s1_t         s1;
  s2_t         s2;
  s3_t         s3;
  carry_t      s4;

  logic        sq_v [SQRT_STEPS+1];
  sqrt_st_t    sq_st [SQRT_STEPS+1];
  carry_t      sq_c [SQRT_STEPS+1];

  logic        rt_v, dn_v, ic_v;
  root_t       rt;
  root_t       dn;
  root_t       ic;

  logic        dv_v [DIV_STEPS+1];
  div_st_t     dv_st [DIV_STEPS+1];
  carry_t      dv_c [DIV_STEPS+1];

  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      adam_enable  <= 1'b1;
      step_size    <= RST_STEP_SIZE;
      beta_one     <= RST_BETA_ONE;
      beta_two     <= RST_BETA_TWO;
      epsilon_term <= RST_EPSILON;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_ADAM_ENABLE: adam_enable  <= wr_data[0];
        CFG_STEP_SIZE:   step_size    <= wr_data;
        CFG_BETA_ONE:    beta_one     <= wr_data;
        CFG_BETA_TWO:    beta_two     <= wr_data;
        CFG_EPSILON:     epsilon_term <= wr_data;
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      for (int k = 0; k <= SQRT_STEPS; k++) sq_v[k] <= 1'b0;
      rt_v <= 1'b0;
      dn_v <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_v[k] <= 1'b0;
      ic_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v     <= accept;
      s2_v     <= s1_v;
      s3_v     <= s2_v;
      s4_v     <= s3_v;
      sq_v[0]  <= s4_v;
      for (int k = 1; k <= SQRT_STEPS; k++) sq_v[k] <= sq_v[k-1];
      rt_v     <= sq_v[SQRT_STEPS];
      dn_v     <= rt_v;
      dv_v[0]  <= dn_v;
      for (int k = 1; k <= DIV_STEPS; k++) dv_v[k] <= dv_v[k-1];
      ic_v     <= dv_v[DIV_STEPS];
      done     <= ic_v;
    end
  end

  // Stage 1: decay products and (1 - beta) terms; mirror replaces the weight when off
  always_ff @(posedge clk) begin
    s1.w    <= adam_enable ? item.weight_in : item.mirror_in;
    s1.g    <= item.grad_accum;
    s1.m    <= item.moment_in;
    s1.v    <= item.velocity_in;
    s1.a1   <= fp_mul(beta_one, item.moment_in);
    s1.a2   <= fp_mul(beta_two, item.velocity_in);
    s1.c1   <= fp_add(FP_ONE, {~beta_one[31], beta_one[30:0]});
    s1.c2   <= fp_add(FP_ONE, {~beta_two[31], beta_two[30:0]});
    s1.last <= item.last_element;
  end

  // Stage 2: gradient terms
  always_ff @(posedge clk) begin
    s2.w    <= s1.w;
    s2.g    <= s1.g;
    s2.m    <= s1.m;
    s2.v    <= s1.v;
    s2.a1   <= s1.a1;
    s2.a2   <= s1.a2;
    s2.t1   <= fp_mul(s1.c1, s1.g);
    s2.t2   <= fp_mul(s1.c2, s1.g);
    s2.last <= s1.last;
  end

  // Stage 3: new moment, squared gradient term
  always_ff @(posedge clk) begin
    s3.w    <= s2.w;
    s3.v    <= s2.v;
    s3.a2   <= s2.a2;
    s3.mom  <= adam_enable ? fp_add(s2.a1, s2.t1) : s2.m;
    s3.t3   <= fp_mul(s2.t2, s2.g);
    s3.last <= s2.last;
  end

  // Stage 4: new velocity, step numerator
  always_ff @(posedge clk) begin
    s4.w    <= s3.w;
    s4.mom  <= s3.mom;
    s4.vel  <= adam_enable ? fp_add(s3.a2, s3.t3) : s3.v;
    s4.num  <= fp_mul(step_size, s3.mom);
    s4.last <= s3.last;
  end

  // Square root of the velocity, one root bit per stage
  always_ff @(posedge clk) begin
    sq_st[0] <= sqrt_init(s4.vel);
    sq_c[0]  <= s4;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      sq_st[k] <= sqrt_step(sq_st[k-1]);
      sq_c[k]  <= sq_c[k-1];
    end
  end

  // Root rounding, then epsilon add
  always_ff @(posedge clk) begin
    rt.c <= sq_c[SQRT_STEPS];
    rt.x <= sqrt_finish(sq_st[SQRT_STEPS]);
    dn.c <= rt.c;
    dn.x <= fp_add(rt.x, epsilon_term);
  end

  // Numerator over denominator, one quotient bit per stage
  always_ff @(posedge clk) begin
    dv_st[0] <= div_init(dn.c.num, dn.x);
    dv_c[0]  <= dn.c;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      dv_st[k] <= div_step(dv_st[k-1]);
      dv_c[k]  <= dv_c[k-1];
    end
  end

  // Quotient rounding, then weight add into the result register
  always_ff @(posedge clk) begin
    ic.c                <= dv_c[DIV_STEPS];
    ic.x                <= div_finish(dv_st[DIV_STEPS]);
    result.weight_out   <= adam_enable ? fp_add(ic.c.w, ic.x) : ic.c.w;
    result.moment_out   <= ic.c.mom;
    result.velocity_out <= ic.c.vel;
    result.last_out     <= ic.c.last;
  end

endmodule

// ===== rtl/awu_check.sv =====
module awu_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input awu_pkg::item_t    item,
  input logic              wr_en,
  input logic [2:0]        wr_index,
  input logic [31:0]       wr_data,
  input logic              done,
  input awu_pkg::result_t  result
);
  import awu_pkg::*;

  localparam int CW = $clog2(LATENCY + 1);

  logic          acc;
  logic [CW-1:0] since_rst;
  logic          en_seen;

  assign acc = start && !busy;

  // Cycles since reset, saturating at the pipeline depth
  always_ff @(posedge clk) begin
    if (rst) since_rst <= '0;
    else if (since_rst != CW'(LATENCY)) since_rst <= since_rst + 1'b1;
  end

  // Shadow of the enable register
  always_ff @(posedge clk) begin
    if (rst) en_seen <= 1'b1;
    else if (wr_en && (wr_index == CFG_ADAM_ENABLE)) en_seen <= wr_data[0];
  end

  // Every strobe matches an item taken one latency earlier
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LATENCY))
    else $error("result strobe without a matching item");

  // Every item taken comes out unless a reset intervened
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    ((since_rst == CW'(LATENCY)) && $past(acc, LATENCY)) |-> done)
    else $error("item lost in pipeline");

  // The end-of-vector flag travels with its item
  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.last_out == $past(item.last_element, LATENCY)))
    else $error("last flag out of order");

  // With the update off the mirror weight and moments pass unchanged
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (done && !en_seen) |->
      ((result.weight_out == $past(item.mirror_in, LATENCY)) &&
       (result.moment_out == $past(item.moment_in, LATENCY)) &&
       (result.velocity_out == $past(item.velocity_in, LATENCY))))
    else $error("bypass result differs from input");

endmodule

bind adam_weight_update awu_check u_awu_check (.*);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awu_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = LATENCY + 8;
  localparam logic [2:0]  IDX_UNUSED  = 3'd5;
  localparam logic [31:0] F_POS_INF   = 32'h7F80_0000;
  localparam logic [31:0] F_MAX_FIN   = 32'h7F7F_FFFF;

  typedef struct {
    logic    adam;
    item_t   it;
    logic    typed;
    result_t want;
  } row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    wr_en;
  logic [2:0]  wr_index;
  logic [31:0] wr_data;
  logic    done;
  result_t result;

  // shadow copy of the block's registers
  logic        sh_enable;
  logic [31:0] sh_step;
  logic [31:0] sh_beta1;
  logic [31:0] sh_beta2;
  logic [31:0] sh_eps;

  result_t pending_q[$];
  int      errors;
  int      cycles;
  logic    idle_on;

  adam_weight_update u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .done     (done),
    .result   (result)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------
  // fp32 arithmetic on bit patterns, round to nearest even
  // ---------------------------------------------------------------
  function automatic logic f_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic f_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // value = m * 2^e
  function automatic void f_split(input logic [31:0] x, output int e,
                                  output logic [63:0] m);
    if (x[30:23] != 8'd0) begin
      m = {40'd0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end else begin
      m = {41'd0, x[22:0]};
      e = -149;
    end
  endfunction

  // normalize so bit 23 is set (nonzero input)
  function automatic void f_norm(inout int e, inout logic [63:0] m);
    while (!m[23]) begin
      m = m << 1;
      e = e - 1;
    end
  endfunction

  // round sign * sig * 2^e (sig nonzero, bit 0 may be sticky)
  function automatic logic [31:0] f_round(logic s, int e, logic [63:0] sig);
    int          be;
    int          sh;
    logic [63:0] t;
    logic        stk;
    logic [24:0] mant;
    longint      bits;
    stk = 1'b0;
    while (!sig[63]) begin
      sig = sig << 1;
      e   = e - 1;
    end
    be = e + 190;
    sh = (be >= 1) ? 0 : 1 - be;
    t  = sig;
    if (sh >= 64) begin
      stk = |t;
      t   = '0;
    end else begin
      for (int i = 0; i < sh; i++) begin
        stk = stk | t[0];
        t   = t >> 1;
      end
    end
    mant = {1'b0, t[63:40]} + 25'(t[39] & (stk | (|t[38:0]) | t[40]));
    if (be >= 256) return {s, F_POS_INF[30:0]};
    bits = (longint'((be >= 1) ? be - 1 : 0) << 23) + longint'(mant);
    if (bits >= longint'(F_POS_INF)) return {s, F_POS_INF[30:0]};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    int          ea;
    int          eb;
    int          d;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] tmp;
    logic [63:0] r;
    logic        stk;
    logic        sa;
    logic        sb;
    logic        s;
    if (f_nan(a) || f_nan(b)) return QNAN;
    if (f_inf(a) && f_inf(b) && (a[31] != b[31])) return QNAN;
    if (f_inf(a)) return a;
    if (f_inf(b)) return b;
    if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
    if (f_zero(a)) return b;
    if (f_zero(b)) return a;
    f_split(a, ea, ma);
    f_split(b, eb, mb);
    sa = a[31];
    sb = b[31];
    // larger exponent goes first
    if (eb > ea) begin
      tmp = ma; ma = mb; mb = tmp;
      d = ea; ea = eb; eb = d;
      s = sa; sa = sb; sb = s;
    end
    d   = ea - eb;
    ma  = ma << 38;
    mb  = mb << 38;
    stk = 1'b0;
    if (d >= 64) begin
      stk = |mb;
      mb  = '0;
    end else begin
      for (int i = 0; i < d; i++) begin
        stk = stk | mb[0];
        mb  = mb >> 1;
      end
    end
    mb = mb | 64'(stk);
    if (sa == sb) begin
      r = ma + mb;
      s = sa;
    end else if (ma >= mb) begin
      r = ma - mb;
      s = sa;
    end else begin
      r = mb - ma;
      s = sb;
    end
    if (r == '0) return 32'd0;
    return f_round(s, ea - 38, r);
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    int          ea;
    int          eb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic        s;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return QNAN;
    if ((f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) return QNAN;
    if (f_inf(a) || f_inf(b)) return {s, F_POS_INF[30:0]};
    if (f_zero(a) || f_zero(b)) return {s, 31'd0};
    f_split(a, ea, ma);
    f_split(b, eb, mb);
    return f_round(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    int          ea;
    int          eb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic [63:0] rem;
    logic        s;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return QNAN;
    if ((f_zero(a) && f_zero(b)) || (f_inf(a) && f_inf(b))) return QNAN;
    if (f_inf(a) || f_zero(b)) return {s, F_POS_INF[30:0]};
    if (f_zero(a) || f_inf(b)) return {s, 31'd0};
    f_split(a, ea, ma);
    f_split(b, eb, mb);
    f_norm(ea, ma);
    f_norm(eb, mb);
    q   = (ma << 39) / mb;
    rem = (ma << 39) % mb;
    return f_round(s, ea - eb - 40, (q << 1) | 64'(rem != '0));
  endfunction

  function automatic logic [31:0] f_sqrt(logic [31:0] x);
    int          e;
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] tr;
    if (f_nan(x)) return QNAN;
    if (f_zero(x)) return x;
    if (x[31]) return QNAN;
    if (f_inf(x)) return x;
    f_split(x, e, m);
    f_norm(e, m);
    if (e % 2 != 0) begin
      m = m << 1;
      e = e - 1;
    end
    n = m << 38;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      tr = r | (64'd1 << i);
      if (tr * tr <= n) r = tr;
    end
    return f_round(1'b0, (e - 38) / 2 - 1, (r << 1) | 64'(r * r != n));
  endfunction

  // expected result of one item under the current register settings
  function automatic result_t adam_predict(item_t it);
    result_t     res;
    logic [31:0] mom;
    logic [31:0] vel;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] den;
    logic [31:0] num;
    res.last_out = it.last_element;
    if (!sh_enable) begin
      res.weight_out   = it.mirror_in;
      res.moment_out   = it.moment_in;
      res.velocity_out = it.velocity_in;
      return res;
    end
    c1  = f_add(FP_ONE, {~sh_beta1[31], sh_beta1[30:0]});
    c2  = f_add(FP_ONE, {~sh_beta2[31], sh_beta2[30:0]});
    mom = f_add(f_mul(sh_beta1, it.moment_in), f_mul(c1, it.grad_accum));
    vel = f_add(f_mul(sh_beta2, it.velocity_in),
                f_mul(f_mul(c2, it.grad_accum), it.grad_accum));
    den = f_add(f_sqrt(vel), sh_eps);
    num = f_mul(sh_step, mom);
    res.weight_out   = f_add(it.weight_in, f_div(num, den));
    res.moment_out   = mom;
    res.velocity_out = vel;
    return res;
  endfunction

  // ---------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result weight_out=%h", result.weight_out);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (result.weight_out !== want.weight_out) begin
          $error("weight_out expected %h actual %h", want.weight_out, result.weight_out);
          errors++;
        end
        if (result.moment_out !== want.moment_out) begin
          $error("moment_out expected %h actual %h", want.moment_out, result.moment_out);
          errors++;
        end
        if (result.velocity_out !== want.velocity_out) begin
          $error("velocity_out expected %h actual %h", want.velocity_out,
                 result.velocity_out);
          errors++;
        end
        if (result.last_out !== want.last_out) begin
          $error("last_out expected %b actual %b", want.last_out, result.last_out);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("adam_weight_update regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------
  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write; block must be idle
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ADAM_ENABLE: sh_enable = data[0];
      CFG_STEP_SIZE:   sh_step   = data;
      CFG_BETA_ONE:    sh_beta1  = data;
      CFG_BETA_TWO:    sh_beta2  = data;
      CFG_EPSILON:     sh_eps    = data;
      default: ;
    endcase
  endtask

  // present one item until accepted; typed expectation overrides the predictor
  // start stays high afterwards so items can follow back to back
  task automatic send_item(item_t it, logic typed, result_t want);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(typed ? want : adam_predict(it));
  endtask

  function automatic logic [31:0] rand_fp(logic pos);
    logic [31:0] x;
    x = $urandom();
    case ($urandom_range(0, 11))
      0: ;
      1: x = {x[31], 31'd0};
      2: x = {x[31], 8'hFF, (x[0] ? x[22:0] : 23'd0)};
      3: x = {x[31], 8'h00, x[22:0]};
      4: x = {x[31], 8'($urandom_range(1, 40)), x[22:0]};
      5: x = {x[31], 8'($urandom_range(215, 254)), x[22:0]};
      default: x = {x[31] & !pos, 8'($urandom_range(100, 135)), x[22:0]};
    endcase
    return x;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.weight_in    = rand_fp(1'b0);
    it.grad_accum   = rand_fp(1'b0);
    it.moment_in    = rand_fp(1'b0);
    it.velocity_in  = rand_fp(1'b1);
    it.mirror_in    = $urandom();
    it.last_element = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    row_t    dir_rows[$];
    result_t none;
    item_t   it;
    none     = '0;
    errors   = 0;
    cycles   = 0;
    idle_on  = 1'b1;
    rst      = 1'b1;
    start    = 1'b0;
    item     = '0;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    sh_enable = 1'b1;
    sh_step   = RST_STEP_SIZE;
    sh_beta1  = RST_BETA_ONE;
    sh_beta2  = RST_BETA_TWO;
    sh_eps    = RST_EPSILON;

    dir_rows = '{
      // reset settings, Adam on
      '{1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, none},
      '{1'b1, '{32'h3F80_0000, 32'h3A83_126F, 32'h3F00_0000, 32'h3F80_0000,
                32'h0, 1'b1}, 1'b0, none},
      '{1'b1, '{32'hC000_0000, 32'hBF80_0000, 32'h8000_0000, 32'h0000_0001,
                32'h1234_5678, 1'b0}, 1'b0, none},
      // all ones: NaN everywhere
      '{1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b1}, 1'b0, none},
      // negative velocity, negative zero velocity
      '{1'b1, '{32'h3F80_0000, 32'h0, 32'h3F80_0000, 32'hBF80_0000,
                32'h0, 1'b0}, 1'b0, none},
      '{1'b1, '{32'h3F80_0000, 32'h0, 32'h3F80_0000, 32'h8000_0000,
                32'h0, 1'b0}, 1'b0, none},
      // infinite velocity and gradient, max finite, subnormals
      '{1'b1, '{32'h3F80_0000, 32'h3F80_0000, 32'h0, 32'h7F80_0000,
                32'h0, 1'b0}, 1'b0, none},
      '{1'b1, '{32'h7F7F_FFFF, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                32'h0, 1'b0}, 1'b0, none},
      '{1'b1, '{32'h807F_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h0000_0003,
                32'h0, 1'b1}, 1'b0, none},
      '{1'b1, '{32'h7F80_0001, 32'h4120_0000, 32'hC2C8_0000, 32'h4479_8000,
                32'h0, 1'b0}, 1'b0, none},
      // Adam off: bit-exact copy, NaN patterns pass untouched
      '{1'b0, '{32'h3F80_0000, 32'h4000_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
                32'h0000_0000, 1'b0}, 1'b1,
        '{32'h0000_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 1'b0}},
      '{1'b0, '{32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1}},
      '{1'b0, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hBF80_0000,
                32'h7F80_0000, 1'b0}, 1'b1,
        '{32'h7F80_0000, 32'h8000_0000, 32'hBF80_0000, 1'b0}}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].adam != sh_enable) begin
        drain();
        reg_write(CFG_ADAM_ENABLE, {31'd0, dir_rows[i].adam});
      end
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // extreme register settings, each with a few items
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          reg_write(CFG_ADAM_ENABLE, 32'hFFFF_FFFF);
          reg_write(CFG_STEP_SIZE, 32'hFFFF_FFFF);
          reg_write(CFG_BETA_ONE, 32'h0);
          reg_write(CFG_BETA_TWO, FP_ONE);
          reg_write(CFG_EPSILON, 32'h0);
        end
        1: begin
          reg_write(CFG_STEP_SIZE, F_MAX_FIN);
          reg_write(CFG_BETA_ONE, FP_ONE);
          reg_write(CFG_BETA_TWO, 32'h0);
          reg_write(CFG_EPSILON, F_MAX_FIN);
        end
        2: begin
          reg_write(CFG_STEP_SIZE, 32'h0);
          reg_write(CFG_BETA_ONE, 32'hFFFF_FFFF);
          reg_write(CFG_BETA_TWO, 32'h7F80_0000);
          reg_write(CFG_EPSILON, 32'hFFFF_FFFF);
        end
        3: begin
          reg_write(CFG_STEP_SIZE, 32'h8000_0001);
          reg_write(CFG_BETA_ONE, 32'h0000_0001);
          reg_write(CFG_BETA_TWO, 32'h3F00_0000);
          reg_write(CFG_EPSILON, 32'h0000_0001);
          // out-of-range index must leave every register alone
          reg_write(IDX_UNUSED, 32'hFFFF_FFFF);
        end
        4: begin
          reg_write(CFG_STEP_SIZE, RST_STEP_SIZE);
          reg_write(CFG_BETA_ONE, RST_BETA_ONE);
          reg_write(CFG_BETA_TWO, RST_BETA_TWO);
          reg_write(CFG_EPSILON, RST_EPSILON);
        end
        default: reg_write(CFG_STEP_SIZE, 32'hBA83_126F);
      endcase
      repeat (20) send_item(rand_item(), 1'b0, none);
    end

    // random phases with random but plausible settings
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      reg_write(CFG_ADAM_ENABLE, {31'd0, ($urandom_range(0, 4) != 0)});
      reg_write(CFG_STEP_SIZE, (ph % 4 == 3) ? $urandom() :
                {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 125)),
                 23'($urandom())});
      reg_write(CFG_BETA_ONE, {1'b0, 8'($urandom_range(120, 126)), 23'($urandom())});
      reg_write(CFG_BETA_TWO, {1'b0, 8'd126, 23'($urandom())});
      reg_write(CFG_EPSILON, (ph % 5 == 4) ? $urandom() :
                {1'b0, 8'($urandom_range(90, 110)), 23'($urandom())});
      idle_on = (ph != 6);
      repeat (120) begin
        it = rand_item();
        if ($urandom_range(0, 9) == 0) begin
          it = item_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        1'($urandom())});
        end
        send_item(it, 1'b0, none);
      end
    end
    idle_on = 1'b1;

    drain();
    if (errors == 0) begin
      $display("adam_weight_update regression: pass");
    end else begin
      $display("adam_weight_update regression: fail");
    end
    $finish;
  end

endmodule
